// ===== design/assert_macros.svh =====
// Assertion helpers used by array_cursor_list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ACL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/acl_pkg.sv =====
`default_nettype none

package acl_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int PORT_DATA_W    = 32;
    localparam int PORT_POS_W     = 6;
    localparam int PORT_COUNT_W   = 7;

    typedef enum logic [3:0] {
        CMD_READ_CUR  = 4'd0,
        CMD_WRITE_CUR = 4'd1,
        CMD_PREV      = 4'd2,
        CMD_NEXT      = 4'd3,
        CMD_FIRST     = 4'd4,
        CMD_LAST      = 4'd5,
        CMD_DELETE    = 4'd6,
        CMD_INS_BEFORE = 4'd7,
        CMD_INS_AFTER = 4'd8,
        CMD_READ_IDX  = 4'd9,
        CMD_WRITE_IDX = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE,
        CELL_READ
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_t;

endpackage

`default_nettype wire

// ===== design/array_cursor_list.sv =====
// Timing: every command but reads registers its result directly; a read by cursor
//   or index k drains through the cell chain while the read counter counts down.
// Flow: one request in flight; next request taken once the result is free; a read
//   holds off new requests until the read carry chain has drained to cell 0.
// Reset: count and cursor clear to zero; element cells are not reset.
`default_nettype none

`include "assert_macros.svh"

module array_cursor_list #(
    parameter int CAPACITY   = acl_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = acl_pkg::DEF_DATA_WIDTH
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [3:0]                       command,
    input  wire  [acl_pkg::PORT_DATA_W-1:0]  data_value,
    input  wire  [acl_pkg::PORT_POS_W-1:0]   position,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [acl_pkg::PORT_DATA_W-1:0]  read_value,
    output logic                             moved,
    output logic [1:0]                       status,
    output logic [acl_pkg::PORT_COUNT_W-1:0] element_count,
    output logic [acl_pkg::PORT_POS_W-1:0]   cursor_index
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int SW = (DATA_WIDTH < acl_pkg::PORT_DATA_W) ? DATA_WIDTH
                                                            : acl_pkg::PORT_DATA_W;

    acl_pkg::fsm_t    state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    cursor_reg, cursor_next;
    logic [IW-1:0]    rd_cnt_reg, rd_cnt_next;

    logic                             out_valid_reg, out_valid_next;
    logic [acl_pkg::PORT_DATA_W-1:0]  rd_val_reg, rd_val_next;
    logic                             moved_reg, moved_next;
    acl_pkg::status_t                 status_reg, status_next;
    logic [acl_pkg::PORT_COUNT_W-1:0] ecount_reg, ecount_next;
    logic [acl_pkg::PORT_POS_W-1:0]   ecursor_reg, ecursor_next;

    acl_pkg::cell_op_t cell_op;
    logic [IW-1:0]     cell_idx;
    logic [SW-1:0]     wr_data;
    logic [SW-1:0]     cell_data  [CAPACITY];
    logic [SW-1:0]     cell_carry [CAPACITY];

    logic accept;
    logic out_take;

    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = !((state_reg == acl_pkg::FSM_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;
    assign wr_data  = SW'(data_value);

    always_comb
    begin
        acl_pkg::cell_op_t op_c;
        logic [IW-1:0]     idx_c;
        logic [CW-1:0]     cnt_c;
        logic [IW-1:0]     cur_c;
        acl_pkg::status_t  sts_c;
        logic              mov_c;
        logic              rd_go;
        logic              empty;
        logic              pos_bad;

        op_c    = acl_pkg::CELL_HOLD;
        idx_c   = cursor_reg;
        cnt_c   = count_reg;
        cur_c   = cursor_reg;
        sts_c   = acl_pkg::STS_OK;
        mov_c   = 1'b0;
        rd_go   = 1'b0;
        empty   = (count_reg == '0);
        pos_bad = (32'(position) >= 32'(count_reg));

        if (empty && (command inside {[acl_pkg::CMD_READ_CUR:acl_pkg::CMD_DELETE]}))
        begin
            sts_c = acl_pkg::STS_EMPTY;
        end
        else
        begin
            case (command)
                acl_pkg::CMD_READ_CUR:
                begin
                    op_c  = acl_pkg::CELL_READ;
                    rd_go = 1'b1;
                end
                acl_pkg::CMD_WRITE_CUR:
                begin
                    op_c = acl_pkg::CELL_WRITE;
                end
                acl_pkg::CMD_PREV:
                begin
                    if (cursor_reg != '0)
                    begin
                        cur_c = cursor_reg - IW'(1);
                        mov_c = 1'b1;
                    end
                end
                acl_pkg::CMD_NEXT:
                begin
                    if (CW'(cursor_reg) + CW'(1) < count_reg)
                    begin
                        cur_c = cursor_reg + IW'(1);
                        mov_c = 1'b1;
                    end
                end
                acl_pkg::CMD_FIRST:
                begin
                    cur_c = '0;
                end
                acl_pkg::CMD_LAST:
                begin
                    cur_c = IW'(count_reg - CW'(1));
                end
                acl_pkg::CMD_DELETE:
                begin
                    op_c  = acl_pkg::CELL_DELETE;
                    cnt_c = count_reg - CW'(1);
                    if ((CW'(cursor_reg) == count_reg - CW'(1)) && (cursor_reg != '0))
                    begin
                        cur_c = cursor_reg - IW'(1);
                    end
                end
                acl_pkg::CMD_INS_BEFORE, acl_pkg::CMD_INS_AFTER:
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        sts_c = acl_pkg::STS_FULL;
                    end
                    else
                    begin
                        op_c  = acl_pkg::CELL_INSERT;
                        cnt_c = count_reg + CW'(1);
                        if (empty)
                        begin
                            idx_c = '0;
                        end
                        else if (command == acl_pkg::CMD_INS_BEFORE)
                        begin
                            idx_c = cursor_reg;
                            cur_c = cursor_reg + IW'(1);
                        end
                        else
                        begin
                            idx_c = cursor_reg + IW'(1);
                        end
                    end
                end
                acl_pkg::CMD_READ_IDX:
                begin
                    if (pos_bad)
                    begin
                        sts_c = acl_pkg::STS_RANGE;
                    end
                    else
                    begin
                        op_c  = acl_pkg::CELL_READ;
                        idx_c = IW'(position);
                        rd_go = 1'b1;
                    end
                end
                acl_pkg::CMD_WRITE_IDX:
                begin
                    if (pos_bad)
                    begin
                        sts_c = acl_pkg::STS_RANGE;
                    end
                    else
                    begin
                        op_c  = acl_pkg::CELL_WRITE;
                        idx_c = IW'(position);
                    end
                end
                default:
                begin
                    op_c = acl_pkg::CELL_HOLD;
                end
            endcase
        end

        cell_op        = acl_pkg::CELL_HOLD;
        cell_idx       = idx_c;
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        rd_cnt_next    = rd_cnt_reg;
        out_valid_next = out_valid_reg && !out_take;
        rd_val_next    = rd_val_reg;
        moved_next     = moved_reg;
        status_next    = status_reg;
        ecount_next    = ecount_reg;
        ecursor_next   = ecursor_reg;

        case (state_reg)
            acl_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    cell_op     = op_c;
                    count_next  = cnt_c;
                    cursor_next = cur_c;
                    if (rd_go)
                    begin
                        state_next  = acl_pkg::FSM_READ;
                        rd_cnt_next = idx_c;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        rd_val_next    = '0;
                        moved_next     = mov_c;
                        status_next    = sts_c;
                        ecount_next    = acl_pkg::PORT_COUNT_W'(cnt_c);
                        ecursor_next   = acl_pkg::PORT_POS_W'(cur_c);
                    end
                end
            end
            acl_pkg::FSM_READ:
            begin
                if (rd_cnt_reg == '0)
                begin
                    state_next     = acl_pkg::FSM_IDLE;
                    out_valid_next = 1'b1;
                    rd_val_next    = acl_pkg::PORT_DATA_W'(cell_carry[0]);
                    moved_next     = 1'b0;
                    status_next    = acl_pkg::STS_OK;
                    ecount_next    = acl_pkg::PORT_COUNT_W'(count_reg);
                    ecursor_next   = acl_pkg::PORT_POS_W'(cursor_reg);
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg - IW'(1);
                end
            end
            default:
            begin
                state_next = acl_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acl_pkg::FSM_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_val_reg  <= rd_val_next;
        moved_reg   <= moved_next;
        status_reg  <= status_next;
        ecount_reg  <= ecount_next;
        ecursor_reg <= ecursor_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [SW-1:0] left_d;
            logic [SW-1:0] right_d;
            logic [SW-1:0] right_c;

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
                assign right_c = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
                assign right_c = cell_carry[gi+1];
            end

            acl_cell #(
                .IDX_W  (IW),
                .DATA_W (SW),
                .INDEX  (gi)
            ) u_cell (
                .clk         (clk),
                .op          (cell_op),
                .sel_idx     (cell_idx),
                .wr_data     (wr_data),
                .left_data   (left_d),
                .right_data  (right_d),
                .right_carry (right_c),
                .data_out    (cell_data[gi]),
                .carry_out   (cell_carry[gi])
            );
        end
    endgenerate

    assign out_valid     = out_valid_reg;
    assign read_value    = rd_val_reg;
    assign moved         = moved_reg;
    assign status        = status_reg;
    assign element_count = ecount_reg;
    assign cursor_index  = ecursor_reg;

    `ACL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count over capacity")
    `ACL_ASSERT_NOW(a_empty_cursor, clk, rst_n, count_reg == '0, cursor_reg == '0, "cursor set on empty list")
    `ACL_ASSERT_NOW(a_cursor_in_list, clk, rst_n, count_reg != '0, CW'(cursor_reg) < count_reg, "cursor past end")
    `ACL_ASSERT_NEXT(a_read_pending, clk, rst_n, state_reg == acl_pkg::FSM_READ && rd_cnt_reg != '0, state_reg == acl_pkg::FSM_READ && !out_valid_reg, "read finished early")

endmodule

`default_nettype wire

// ===== design/acl_cell.sv =====
`default_nettype none

module acl_cell #(
    parameter int IDX_W  = 6,
    parameter int DATA_W = 32,
    parameter int INDEX  = 0
) (
    input  wire                     clk,
    input  acl_pkg::cell_op_t       op,
    input  wire  [IDX_W-1:0]        sel_idx,
    input  wire  [DATA_W-1:0]       wr_data,
    input  wire  [DATA_W-1:0]       left_data,
    input  wire  [DATA_W-1:0]       right_data,
    input  wire  [DATA_W-1:0]       right_carry,
    output logic [DATA_W-1:0]       data_out,
    output logic [DATA_W-1:0]       carry_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] carry_reg;
    logic [DATA_W-1:0] carry_next;

    always_comb
    begin
        data_next  = data_reg;
        carry_next = right_carry;
        case (op)
            acl_pkg::CELL_WRITE:
            begin
                if (sel_idx == MY_IDX)
                begin
                    data_next = wr_data;
                end
            end
            acl_pkg::CELL_INSERT:
            begin
                if (sel_idx == MY_IDX)
                begin
                    data_next = wr_data;
                end
                else if (MY_IDX > sel_idx)
                begin
                    data_next = left_data;
                end
            end
            acl_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= sel_idx)
                begin
                    data_next = right_data;
                end
            end
            acl_pkg::CELL_READ:
            begin
                if (sel_idx == MY_IDX)
                begin
                    carry_next = data_reg;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        carry_reg <= carry_next;
    end

    assign data_out  = data_reg;
    assign carry_out = carry_reg;

endmodule

`default_nettype wire
